[rtl/axrsc_pkg.sv]
// Shared types and constants for the add-xor-rotate stream cipher unit.
// Used by the mix datapath, the word ring and the top level. No dependencies.
package axrsc_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned WORD_COUNT = 8;
  localparam int unsigned ROT_AMT    = 2;
  localparam int unsigned STEP_W     = $clog2(WORD_COUNT);
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO  = 3'd5;

  // Item opcodes.
  localparam logic OP_REKEY = 1'b0;
  localparam logic OP_CRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WORD_COUNT-1:0][WORD_W-1:0] ring_t;

  // Control of the word ring: a parallel load or one rotate-and-update step.
  typedef struct packed {
    logic load;
    logic step;
  } ring_ctrl_t;

  // Operands of the shared mix unit: four addends and an XOR mask.
  typedef struct packed {
    word_t add_a;
    word_t add_b;
    word_t add_c;
    word_t add_d;
    word_t xor_m;
  } mix_op_t;

endpackage

[rtl/add_xor_rotate_stream_cipher_unit.sv]
// Add-xor-rotate stream cipher unit: one shared mix unit under a small sequencer.
// Crypt: one word update per cycle over the 8 steps of a round, then an output
// state that waits for a free output register; a new item is taken only in idle.
// Rekey: a load state, then SETUP_ROUNDS rounds of 8 steps, no result. The 8-step
// chain of dependent word updates runs through the single mix unit.
// Reset (asynchronous, active low) clears the ring, key sum, config and control state.
module add_xor_rotate_stream_cipher_unit #(
  parameter int unsigned SETUP_ROUNDS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [axrsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [axrsc_pkg::WORD_W-1:0]         cfg_wdata_i,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic [axrsc_pkg::WORD_W-1:0]         data_word_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [axrsc_pkg::WORD_W-1:0]         crypt_word_o
);

  localparam int unsigned ROUND_W = (SETUP_ROUNDS > 1) ? $clog2(SETUP_ROUNDS) : 1;
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(SETUP_ROUNDS - 1);
  localparam logic [axrsc_pkg::STEP_W-1:0] LAST_STEP =
    axrsc_pkg::STEP_W'(axrsc_pkg::WORD_COUNT - 1);

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Configuration registers. They only take effect at the next rekey.
  axrsc_pkg::word_t key0_q, key1_q, key2_q, key3_q, nonce_hi_q, nonce_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce_hi_q <= '0;
      nonce_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        axrsc_pkg::REG_KEY0:     key0_q     <= cfg_wdata_i;
        axrsc_pkg::REG_KEY1:     key1_q     <= cfg_wdata_i;
        axrsc_pkg::REG_KEY2:     key2_q     <= cfg_wdata_i;
        axrsc_pkg::REG_KEY3:     key3_q     <= cfg_wdata_i;
        axrsc_pkg::REG_NONCE_HI: nonce_hi_q <= cfg_wdata_i;
        axrsc_pkg::REG_NONCE_LO: nonce_lo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [1:0]                      state_q, state_d;
  logic [axrsc_pkg::STEP_W-1:0]    step_q, step_d;
  logic [ROUND_W-1:0]              round_q, round_d;
  logic                            crypt_q, crypt_d;
  axrsc_pkg::word_t                key_sum_q, key_sum_d;
  // The running round sum is kept as two parts (sum_q + last_q) so that each
  // cycle needs only one four-operand add in the mix unit.
  axrsc_pkg::word_t                sum_q, sum_d;
  axrsc_pkg::word_t                last_q, last_d;
  axrsc_pkg::word_t                data_q, data_d;
  logic                            out_valid_q, out_valid_d;
  axrsc_pkg::word_t                out_word_q, out_word_d;

  axrsc_pkg::ring_ctrl_t           ring_ctrl;
  axrsc_pkg::ring_t                ring_load;
  axrsc_pkg::ring_t                ring_words;
  axrsc_pkg::mix_op_t              mix_op;
  axrsc_pkg::word_t                mix_sum;
  axrsc_pkg::word_t                mix_word;

  logic in_xfer;
  logic out_xfer;
  logic fin_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;
  assign fin_fire   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Rekey load image: key words with the nonce folded into words 0 and 1.
  always_comb begin
    ring_load    = '0;
    ring_load[0] = key0_q ^ nonce_hi_q;
    ring_load[1] = key1_q ^ nonce_lo_q;
    ring_load[2] = key2_q;
    ring_load[3] = key3_q;
  end

  // Operand selection for the shared mix unit. In the load cycle it totals the
  // initial state words into the key sum, in a round it performs one word
  // update, and in the final cycle it forms w1 + w7 for the keystream.
  always_comb begin
    mix_op = '0;
    case (state_q)
      ST_LOAD: begin
        mix_op.add_a = ring_load[0];
        mix_op.add_b = ring_load[1];
        mix_op.add_c = ring_load[2];
        mix_op.add_d = ring_load[3];
      end
      ST_ROUND: begin
        mix_op.add_a = ring_words[0];
        mix_op.add_b = ring_words[1];
        mix_op.add_c = sum_q;
        mix_op.add_d = last_q;
        mix_op.xor_m = ring_words[2];
      end
      ST_FIN: begin
        mix_op.add_a = ring_words[1];
        mix_op.add_b = ring_words[axrsc_pkg::WORD_COUNT-1];
      end
      default: ;
    endcase
  end

  axrsc_mix_unit u_mix (
    .op_i   (mix_op),
    .sum_o  (mix_sum),
    .word_o (mix_word)
  );

  axrsc_word_ring u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ring_ctrl),
    .load_words_i (ring_load),
    .new_word_i   (mix_word),
    .words_o      (ring_words)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    round_d     = round_q;
    crypt_d     = crypt_q;
    key_sum_d   = key_sum_q;
    sum_d       = sum_q;
    last_d      = last_q;
    data_d      = data_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && !out_xfer;
    ring_ctrl   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          step_d  = '0;
          round_d = '0;
          if (opcode_i == axrsc_pkg::OP_REKEY) begin
            state_d = ST_LOAD;
          end else begin
            // A crypt item runs a single round on the current state.
            crypt_d = 1'b1;
            data_d  = data_word_i;
            sum_d   = key_sum_q;
            last_d  = '0;
            state_d = ST_ROUND;
          end
        end
      end
      ST_LOAD: begin
        ring_ctrl.load = 1'b1;
        key_sum_d      = mix_sum;
        sum_d          = mix_sum;
        last_d         = '0;
        crypt_d        = 1'b0;
        state_d        = ST_ROUND;
      end
      ST_ROUND: begin
        ring_ctrl.step = 1'b1;
        step_d         = step_q + 1'b1;
        sum_d          = sum_q + last_q;
        last_d         = mix_word;
        if (step_q == LAST_STEP) begin
          if (crypt_q) begin
            state_d = ST_FIN;
          end else if (round_q == LAST_ROUND) begin
            state_d = ST_IDLE;
          end else begin
            // Every round restarts its running sum from the key sum.
            round_d = round_q + 1'b1;
            sum_d   = key_sum_q;
            last_d  = '0;
          end
        end
      end
      ST_FIN: begin
        // Hold here until the output register is free.
        if (fin_fire) begin
          out_word_d  = data_q ^ mix_sum ^ ring_words[3] ^ ring_words[5];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      round_q     <= '0;
      crypt_q     <= 1'b0;
      key_sum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      round_q     <= round_d;
      crypt_q     <= crypt_d;
      key_sum_q   <= key_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    last_q     <= last_d;
    data_q     <= data_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o  = out_valid_q;
  assign crypt_word_o = out_word_q;

  // The step counter is back at zero whenever the sequencer waits for work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (step_q == '0))
    else $error("step counter not cleared in idle");

  // An accepted rekey goes to the load cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && opcode_i == axrsc_pkg::OP_REKEY) |=> (state_q == ST_LOAD))
    else $error("rekey did not start with a load");

  // The last step of a crypt round always leads to the output cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && step_q == LAST_STEP && crypt_q) |=> (state_q == ST_FIN))
    else $error("crypt round did not finish into the output cycle");

  // A finished result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i)
      |=> (state_q == ST_FIN && $stable(out_word_q)))
    else $error("result overwritten while output stalled");

  // The round counter never passes the last setup round.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_q <= LAST_ROUND)
    else $error("round counter out of range");

endmodule

[rtl/axrsc_mix_unit.sv]
// Shared arithmetic unit: a four-operand 64-bit add, an XOR and a fixed left rotate.
// Depends on axrsc_pkg.
module axrsc_mix_unit (
  input  axrsc_pkg::mix_op_t op_i,
  output axrsc_pkg::word_t   sum_o,
  output axrsc_pkg::word_t   word_o
);

  axrsc_pkg::word_t mixed;

  assign sum_o  = op_i.add_a + op_i.add_b + op_i.add_c + op_i.add_d;
  assign mixed  = sum_o ^ op_i.xor_m;
  assign word_o = {mixed[axrsc_pkg::WORD_W-1-axrsc_pkg::ROT_AMT:0],
                   mixed[axrsc_pkg::WORD_W-1:axrsc_pkg::WORD_W-axrsc_pkg::ROT_AMT]};

endmodule

[rtl/axrsc_word_ring.sv]
// Eight-word state ring. Each step retires the word at tap 0 to tap 7 as its
// updated value and moves the others down by one. Depends on axrsc_pkg.
module axrsc_word_ring (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  axrsc_pkg::ring_ctrl_t ctrl_i,
  input  axrsc_pkg::ring_t      load_words_i,
  input  axrsc_pkg::word_t      new_word_i,
  output axrsc_pkg::ring_t      words_o
);

  axrsc_pkg::ring_t words_q;
  axrsc_pkg::ring_t words_d;

  always_comb begin
    words_d = words_q;
    if (ctrl_i.load) begin
      words_d = load_words_i;
    end else if (ctrl_i.step) begin
      for (int k = 0; k < axrsc_pkg::WORD_COUNT - 1; k++) begin
        words_d[k] = words_q[k+1];
      end
      words_d[axrsc_pkg::WORD_COUNT-1] = new_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
    end else begin
      words_q <= words_d;
    end
  end

  assign words_o = words_q;

endmodule
